/* design/mstg_pkg.sv */
// mstg_pkg: shared types, constants, note table and control store for the
// square tone generator. No dependencies; used by every design file.
`timescale 1ns / 1ps

package mstg_pkg;

    // item kinds carried on s_tuser
    localparam logic [1:0] OP_EVENT  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;

    // midi command nibbles
    localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
    localparam logic [3:0] CMD_NOTE_ON  = 4'h9;

    localparam logic [7:0] VOLUME_RESET = 8'd12;
    localparam logic       REG_VOLUME   = 1'b0;

    // key -> table distance: key + 12*octave_span - base_key
    localparam int unsigned BASE_KEY    = 129;
    localparam int unsigned OCTAVE_SPAN = 11;
    localparam logic [7:0]  KEY_OFFSET  = 8'(12 * OCTAVE_SPAN - BASE_KEY);
    // floor(d / 12) == (d * 171) >> 11 for d below 256
    localparam logic [7:0]  RECIP_12    = 8'd171;
    localparam int unsigned RECIP_SHIFT = 11;

    typedef logic [3:0] pc_t;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_ACCEPT,
        UOP_LOOKUP,
        UOP_STEP,
        UOP_PHASE,
        UOP_CLASS,
        UOP_MUL,
        UOP_DIV,
        UOP_FINISH,
        UOP_ZERO,
        UOP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NOT_SAMPLE,
        COND_SILENT,
        COND_FLAT,
        COND_DIV_MORE
    } cond_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        pc_t   target;
    } ucode_t;

    typedef struct packed {
        uop_t uop;
        logic fire;
        logic in_ready;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic not_sample;
        logic silent;
        logic flat;
        logic div_more;
    } status_t;

    localparam pc_t PC_ACCEPT = 4'd0;
    localparam pc_t PC_LOOKUP = 4'd1;
    localparam pc_t PC_STEP   = 4'd2;
    localparam pc_t PC_PHASE  = 4'd3;
    localparam pc_t PC_CLASS  = 4'd4;
    localparam pc_t PC_MUL    = 4'd5;
    localparam pc_t PC_DIV    = 4'd6;
    localparam pc_t PC_FINISH = 4'd7;
    localparam pc_t PC_EMIT   = 4'd8;
    localparam pc_t PC_ZERO   = 4'd9;

    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        unique case (pc)
            PC_ACCEPT: w = '{UOP_ACCEPT, COND_NOT_SAMPLE, PC_ACCEPT};
            PC_LOOKUP: w = '{UOP_LOOKUP, COND_SILENT,     PC_ZERO};
            PC_STEP:   w = '{UOP_STEP,   COND_NEXT,       PC_ACCEPT};
            PC_PHASE:  w = '{UOP_PHASE,  COND_NEXT,       PC_ACCEPT};
            PC_CLASS:  w = '{UOP_CLASS,  COND_FLAT,       PC_EMIT};
            PC_MUL:    w = '{UOP_MUL,    COND_NEXT,       PC_ACCEPT};
            PC_DIV:    w = '{UOP_DIV,    COND_DIV_MORE,   PC_DIV};
            PC_FINISH: w = '{UOP_FINISH, COND_NEXT,       PC_ACCEPT};
            PC_EMIT:   w = '{UOP_EMIT,   COND_ALWAYS,     PC_ACCEPT};
            PC_ZERO:   w = '{UOP_ZERO,   COND_ALWAYS,     PC_EMIT};
            default:   w = '{UOP_NOP,    COND_ALWAYS,     PC_ACCEPT};
        endcase
        return w;
    endfunction

    // top octave step per semitone
    function automatic logic [15:0] semitone_step(input logic [3:0] idx);
        logic [15:0] s;
        case (idx)
            4'd0:    s = 16'd28160;
            4'd1:    s = 16'd29834;
            4'd2:    s = 16'd31608;
            4'd3:    s = 16'd33488;
            4'd4:    s = 16'd35479;
            4'd5:    s = 16'd37589;
            4'd6:    s = 16'd39824;
            4'd7:    s = 16'd42192;
            4'd8:    s = 16'd44701;
            4'd9:    s = 16'd47359;
            4'd10:   s = 16'd50175;
            4'd11:   s = 16'd53159;
            default: s = 16'd0;
        endcase
        return s;
    endfunction

endpackage

/* design/mstg_sequencer.sv */
// mstg_sequencer: step counter, control store fetch and conditional jumps.
// Depends on mstg_pkg.
`timescale 1ns / 1ps

module mstg_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  mstg_pkg::status_t status,
    output mstg_pkg::ctrl_t   ctrl
);

    mstg_pkg::pc_t    pc_reg;
    mstg_pkg::pc_t    pc_next;
    mstg_pkg::ucode_t word;
    logic             stall;
    logic             jump;

    always_comb begin
        word  = mstg_pkg::ucode_rom(pc_reg);
        // hold on an empty input or a full output slot
        stall = ((word.uop == mstg_pkg::UOP_ACCEPT) && !status.in_valid) ||
                ((word.uop == mstg_pkg::UOP_EMIT) && status.out_busy);
        case (word.cond)
            mstg_pkg::COND_ALWAYS:     jump = 1'b1;
            mstg_pkg::COND_NOT_SAMPLE: jump = status.not_sample;
            mstg_pkg::COND_SILENT:     jump = status.silent;
            mstg_pkg::COND_FLAT:       jump = status.flat;
            mstg_pkg::COND_DIV_MORE:   jump = status.div_more;
            default:                   jump = 1'b0;
        endcase
        pc_next = pc_reg;
        if (!stall) begin
            pc_next = jump ? word.target : pc_reg + 4'd1;
        end
        ctrl.uop      = word.uop;
        ctrl.fire     = !stall;
        ctrl.in_ready = (word.uop == mstg_pkg::UOP_ACCEPT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= mstg_pkg::PC_ACCEPT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* design/mstg_datapath.sv */
// mstg_datapath: key and phase state, step lookup, edge classification,
// multiplier, shift-subtract divider and output register. Depends on mstg_pkg.
`timescale 1ns / 1ps

module mstg_datapath #(
    parameter int unsigned SAMPLE_RATE = 94020
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mstg_pkg::ctrl_t   ctrl,
    output mstg_pkg::status_t status,
    input  logic              in_valid,
    input  logic [1:0]        operation,
    input  logic [7:0]        status_byte,
    input  logic [6:0]        key_number,
    input  logic [6:0]        velocity,
    input  logic [7:0]        volume_level,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [15:0]       sample
);

    localparam logic [17:0] HALF = 18'(SAMPLE_RATE);
    localparam logic [17:0] WRAP = 18'(2 * SAMPLE_RATE);

    logic [6:0]  key_reg,      key_next;
    logic [17:0] phase_reg,    phase_next;
    logic [7:0]  d_reg,        d_next;
    logic [3:0]  oct_reg,      oct_next;
    logic [14:0] step_reg,     step_next;
    logic [14:0] x_reg,        x_next;
    logic        rising_reg,   rising_next;
    logic [14:0] rem_reg,      rem_next;
    logic [15:0] quo_reg,      quo_next;
    logic [3:0]  cnt_reg,      cnt_next;
    logic [15:0] res_reg,      res_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;

    logic [15:0] oct_prod;
    logic [7:0]  oct_x12;
    logic [3:0]  idx;
    logic [15:0] step_full;
    logic [18:0] phase_sum;
    logic [17:0] phase_wrapped;
    logic [18:0] half_plus_step;
    logic        rising;
    logic        falling;
    logic        flat;
    logic [14:0] vol;
    logic [15:0] vol2;
    logic [30:0] prod;
    logic [15:0] trial;
    logic        take;
    logic [16:0] interp;
    logic [3:0]  cmd;
    logic        note_off;

    always_comb begin
        cmd      = status_byte[7:4];
        note_off = (cmd == mstg_pkg::CMD_NOTE_OFF) ||
                   ((cmd == mstg_pkg::CMD_NOTE_ON) && (velocity == 7'd0));

        oct_prod  = (8'(key_reg) + mstg_pkg::KEY_OFFSET) * mstg_pkg::RECIP_12;
        oct_x12   = {1'b0, oct_reg, 3'b000} + {2'b00, oct_reg, 2'b00};
        idx       = 4'(d_reg - oct_x12);
        step_full = mstg_pkg::semitone_step(idx) >> (4'(mstg_pkg::OCTAVE_SPAN) - oct_reg);

        phase_sum     = {1'b0, phase_reg} + {4'b0000, step_reg};
        phase_wrapped = (phase_sum[17:0] >= WRAP) ? phase_sum[17:0] - WRAP : phase_sum[17:0];

        half_plus_step = {1'b0, HALF} + {4'b0000, step_reg};
        rising  = phase_reg < {3'b000, step_reg};
        falling = !rising && (phase_reg >= HALF) && ({1'b0, phase_reg} < half_plus_step);
        flat    = !rising && !falling;

        vol  = {volume_level, 7'b0000000};
        vol2 = {volume_level, 8'b00000000};
        prod = 31'(vol2) * 31'(x_reg);

        // restoring divide: one quotient bit per step
        trial = {rem_reg, quo_reg[15]};
        take  = trial >= {1'b0, step_reg};

        interp = rising_reg ? ({1'b0, quo_reg} - {2'b00, vol})
                            : ({2'b00, vol} - {1'b0, quo_reg});
    end

    always_comb begin
        key_next       = key_reg;
        phase_next     = phase_reg;
        d_next         = d_reg;
        oct_next       = oct_reg;
        step_next      = step_reg;
        x_next         = x_reg;
        rising_next    = rising_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (ctrl.fire) begin
            case (ctrl.uop)
                mstg_pkg::UOP_ACCEPT: begin
                    if (operation == mstg_pkg::OP_EVENT) begin
                        if (note_off) begin
                            if (key_number == key_reg) begin
                                key_next = 7'd0;
                            end
                        end else if (cmd == mstg_pkg::CMD_NOTE_ON) begin
                            key_next = key_number;
                        end
                    end else if (operation == mstg_pkg::OP_STOP) begin
                        key_next = 7'd0;
                    end
                end
                mstg_pkg::UOP_LOOKUP: begin
                    d_next   = 8'(key_reg) + mstg_pkg::KEY_OFFSET;
                    oct_next = 4'(oct_prod >> mstg_pkg::RECIP_SHIFT);
                end
                mstg_pkg::UOP_STEP: begin
                    step_next = step_full[14:0];
                end
                mstg_pkg::UOP_PHASE: begin
                    phase_next = phase_wrapped;
                end
                mstg_pkg::UOP_CLASS: begin
                    rising_next = rising;
                    x_next      = rising ? phase_reg[14:0] : 15'(phase_reg - HALF);
                    res_next    = (phase_reg < HALF) ? {1'b0, vol} : 16'(-{1'b0, vol});
                end
                mstg_pkg::UOP_MUL: begin
                    rem_next = prod[30:16];
                    quo_next = prod[15:0];
                    cnt_next = 4'd0;
                end
                mstg_pkg::UOP_DIV: begin
                    rem_next = take ? 15'(trial - {1'b0, step_reg}) : trial[14:0];
                    quo_next = {quo_reg[14:0], take};
                    cnt_next = cnt_reg + 4'd1;
                end
                mstg_pkg::UOP_FINISH: begin
                    res_next = interp[15:0];
                end
                mstg_pkg::UOP_ZERO: begin
                    res_next = 16'd0;
                end
                mstg_pkg::UOP_EMIT: begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg       <= 7'd0;
            phase_reg     <= 18'd0;
            out_valid_reg <= 1'b0;
        end else begin
            key_reg       <= key_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg        <= d_next;
        oct_reg      <= oct_next;
        step_reg     <= step_next;
        x_reg        <= x_next;
        rising_reg   <= rising_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    always_comb begin
        status.in_valid   = in_valid;
        status.out_busy   = out_valid_reg && !out_ready;
        status.not_sample = operation != mstg_pkg::OP_SAMPLE;
        status.silent     = key_reg == 7'd0;
        status.flat       = flat;
        status.div_more   = cnt_reg != 4'd15;
    end

    assign out_valid = out_valid_reg;
    assign sample    = out_data_reg;

endmodule

/* design/midi_square_tone_generator.sv */
// midi_square_tone_generator: top level with stream ports and the volume register.
// Depends on mstg_pkg, mstg_sequencer and mstg_datapath.
`timescale 1ns / 1ps

// One-voice square-wave tone generator. Note-on and note-off events, the stop item
// and the unused item kind use only the accept step and produce nothing. A sample
// item whose phase step crosses an edge of the square holds the sequencer through
// the accept, key lookup, step lookup, phase update, classification, multiply, divide,
// finish and output steps, and its result is then offered on m_tdata. The one-bit-per-
// cycle divider interpolates the edge into a 16-bit quotient. A sample item away from
// the edges skips the multiply and the divide. A silent voice still gives one zero item
// per sample item, through the accept, lookup, zero and output steps. The next item
// is taken as soon as the program returns to its accept step, even while the last
// result waits on m_tready. Only a second result stalls behind a full output.

module midi_square_tone_generator #(
    parameter int unsigned SAMPLE_RATE = 94020
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // status_byte[7:0], key_number[14:8], velocity[21:15]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sample[15:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    mstg_pkg::ctrl_t   ctrl;
    mstg_pkg::status_t status;
    logic [7:0]        volume_reg;
    logic [7:0]        volume_next;

    assign pready = 1'b1;

    always_comb begin
        volume_next = volume_reg;
        if (psel && penable && pwrite && (paddr[2] == mstg_pkg::REG_VOLUME)) begin
            volume_next = pwdata[7:0];
        end
        prdata = (paddr[2] == mstg_pkg::REG_VOLUME) ? {24'd0, volume_reg} : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_reg <= mstg_pkg::VOLUME_RESET;
        end else begin
            volume_reg <= volume_next;
        end
    end

    mstg_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    mstg_datapath #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .status       (status),
        .in_valid     (s_tvalid),
        .operation    (s_tuser),
        .status_byte  (s_tdata[7:0]),
        .key_number   (s_tdata[14:8]),
        .velocity     (s_tdata[21:15]),
        .volume_level (volume_reg),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .sample       (m_tdata)
    );

    assign s_tready = ctrl.in_ready;

endmodule

/* design/mstg_checker.sv */
// mstg_checker: port-level checks for the tone generator, bound to the top level.
// Depends on mstg_pkg and midi_square_tone_generator.
`timescale 1ns / 1ps

module mstg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // amplitude never exceeds full scale
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata) <= 16'sd32640) && ($signed(m_tdata) >= -16'sd32640))
        else $error("sample out of range");

    // a sample item keeps the input closed while it is worked on
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == mstg_pkg::OP_SAMPLE) |=> !s_tready)
        else $error("input open during sample computation");

    // a new result never appears right after an item was taken
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!(s_tvalid && s_tready)))
        else $error("result appeared one cycle after acceptance");

endmodule

bind midi_square_tone_generator mstg_checker u_mstg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* bench/tone_checker.sv */
// tone_checker: watches the item, result and register ports of the square tone
// generator, predicts every sample and compares it. Depends on mstg_pkg.
`timescale 1ns / 1ps

module tone_checker
    import mstg_pkg::*;
#(
    parameter int unsigned SAMPLE_RATE = 94020
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // status_byte[7:0], key_number[14:8], velocity[21:15]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // sample[15:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        run_done,
    output int unsigned fail_count,
    output int unsigned samples_owed
);

    localparam logic [2:0] VOLUME_ADDR = {REG_VOLUME, 2'b00};
    localparam longint     HALF_WRAP   = longint'(SAMPLE_RATE);
    localparam longint     PHASE_WRAP  = 2 * longint'(SAMPLE_RATE);
    localparam int unsigned MAX_PRINTED = 50;

    logic [6:0]  voice_key;
    logic [17:0] tone_phase;
    logic [7:0]  volume;
    logic [15:0] expected_samples[$];
    logic [15:0] want;
    logic        leftover_checked = 1'b0;
    int unsigned fails = 0;

    task automatic report_mismatch(input string what);
        if (fails < MAX_PRINTED) begin
            $display("tone_checker: %0t %s", $time, what);
        end
        fails++;
    endtask

    // step sizes of the highest octave, one per semitone
    function automatic logic [15:0] top_octave_step(input int unsigned semitone);
        logic [15:0] s;
        case (semitone)
            0:       s = 16'd28160;
            1:       s = 16'd29834;
            2:       s = 16'd31608;
            3:       s = 16'd33488;
            4:       s = 16'd35479;
            5:       s = 16'd37589;
            6:       s = 16'd39824;
            7:       s = 16'd42192;
            8:       s = 16'd44701;
            9:       s = 16'd47359;
            10:      s = 16'd50175;
            default: s = 16'd53159;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] pitch_step(input logic [6:0] key);
        int unsigned key_dist;
        int unsigned octave;
        key_dist = int'(key) + 12 * OCTAVE_SPAN - BASE_KEY;
        octave   = key_dist / 12;
        return top_octave_step(key_dist % 12) >> (OCTAVE_SPAN - octave);
    endfunction

    // moves the phase on by one step and returns the square level at it
    function automatic logic [15:0] advance_tone();
        longint amp;
        longint step;
        longint p;
        longint level;
        amp  = longint'(volume) << 7;
        step = longint'(pitch_step(voice_key));
        p    = (longint'(tone_phase) + step) & 64'h3FFFF;
        if (p >= PHASE_WRAP) begin
            p = p - PHASE_WRAP;
        end
        if (p >= PHASE_WRAP) begin
            p = p % PHASE_WRAP;
        end
        tone_phase = p[17:0];
        // edges crossed since the last sample are interpolated
        if (p < step) begin
            level = -amp + (2 * amp * p) / step;
        end else if (p >= HALF_WRAP && p - step < HALF_WRAP) begin
            level = amp - (2 * amp * (p - HALF_WRAP)) / step;
        end else if (p < HALF_WRAP) begin
            level = amp;
        end else begin
            level = -amp;
        end
        return level[15:0];
    endfunction

    task automatic apply_item(input logic [1:0] op, input logic [7:0] status,
                              input logic [6:0] key, input logic [6:0] vel);
        logic [3:0] cmd;
        cmd = status[7:4];
        case (op)
            OP_EVENT: begin
                if (cmd == CMD_NOTE_OFF || (cmd == CMD_NOTE_ON && vel == '0)) begin
                    if (key == voice_key) begin
                        voice_key = '0;
                    end
                end else if (cmd == CMD_NOTE_ON) begin
                    voice_key = key;
                end
            end
            OP_STOP: begin
                voice_key = '0;
            end
            OP_SAMPLE: begin
                if (voice_key == '0) begin
                    expected_samples.push_back(16'd0);
                end else begin
                    expected_samples.push_back(advance_tone());
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            voice_key  = '0;
            tone_phase = '0;
            volume     = VOLUME_RESET;
            expected_samples.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("sample %0d with none expected",
                                              $signed(m_tdata)));
                end else begin
                    want = expected_samples.pop_front();
                    if (m_tdata !== want) begin
                        report_mismatch($sformatf("sample got %0d want %0d",
                                                  $signed(m_tdata), $signed(want)));
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == VOLUME_ADDR) begin
                volume = pwdata[7:0];
            end
            if (s_tvalid && s_tready) begin
                apply_item(s_tuser, s_tdata[7:0], s_tdata[14:8], s_tdata[21:15]);
            end
            if (run_done && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (expected_samples.size() != 0) begin
                    report_mismatch($sformatf("%0d samples never arrived",
                                              expected_samples.size()));
                end
            end
        end
        fail_count   <= fails;
        samples_owed <= expected_samples.size();
    end

endmodule

/* bench/tb_top.sv */
// tb_top: clock, reset, item and register stimulus for midi_square_tone_generator,
// with random idling on both channels. Depends on mstg_pkg and tone_checker.
`timescale 1ns / 1ps

module tb_top;
    import mstg_pkg::*;

    localparam int unsigned SAMPLE_RATE     = 94020;
    localparam logic [1:0]  OP_IGNORED      = 2'd3;
    localparam logic [2:0]  VOLUME_ADDR     = {REG_VOLUME, 2'b00};
    localparam int unsigned RANDOM_ITEMS    = 1225;
    localparam int unsigned PHASE_ITEMS     = 200;
    localparam int unsigned SETTLE_CYCLES   = 32;   // one sample item plus margin
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned IDLE_LIMIT      = 4000;

    typedef enum int unsigned {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_RUNS
    } ready_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = OP_EVENT;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        run_done = 1'b0;

    int unsigned fail_count;
    int unsigned samples_owed;
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned gap_max     = 0;
    int unsigned holds_asked = 0;
    int unsigned idle_cycles = 0;

    midi_square_tone_generator #(
        .SAMPLE_RATE(SAMPLE_RATE)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tone_checker #(
        .SAMPLE_RATE(SAMPLE_RATE)
    ) u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .run_done    (run_done),
        .fail_count  (fail_count),
        .samples_owed(samples_owed)
    );

    always #5 aclk = ~aclk;

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // result side: changing stall patterns, plus long hold-offs on request
    initial begin : receiver
        ready_mode_t mode;
        int unsigned span;
        int unsigned run_left;
        int unsigned holds_done;
        logic        run_ready;
        span       = 0;
        run_left   = 0;
        holds_done = 0;
        run_ready  = 1'b0;
        mode       = READY_ALWAYS;
        forever begin
            if (holds_done != holds_asked) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            if (span == 0) begin
                mode = ready_mode_t'($urandom_range(3, 0));
                span = $urandom_range(300, 20);
            end
            span--;
            case (mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_COIN:   m_tready <= ($urandom_range(1, 0) == 1);
                READY_SPARSE: m_tready <= ($urandom_range(7, 0) == 0);
                default: begin
                    if (run_left == 0) begin
                        run_left  = $urandom_range(40, 1);
                        run_ready = ~run_ready;
                    end
                    run_left--;
                    m_tready <= run_ready;
                end
            endcase
            @(posedge aclk);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] status,
                             input logic [6:0] key, input logic [6:0] vel);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(40, 1);
            gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, vel, key, status};
        do @(posedge aclk); while (!s_tready);
        if (op != OP_IGNORED) begin
            items_sent++;
        end
    endtask

    task automatic wait_for_samples();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (samples_owed != 0);
    endtask

    task automatic write_volume(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VOLUME_ADDR;
        pwdata  <= {24'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // note-on, a run of samples, then one of the ways a note can end or none, and a last sample
    task automatic play_note();
        logic [6:0] key;
        logic [3:0] chan;
        int unsigned pick;
        int unsigned count;
        pick = $urandom_range(9, 0);
        if (pick < 7) begin
            key = 7'($urandom_range(127, 60));
        end else if (pick < 9) begin
            key = 7'($urandom_range(59, 1));
        end else begin
            key = ($urandom_range(1, 0) == 1) ? 7'd127 : 7'd1;
        end
        chan  = 4'($urandom);
        count = $urandom_range(40, 1);
        send_item(OP_EVENT, {CMD_NOTE_ON, chan}, key, 7'($urandom_range(127, 1)));
        repeat (count) send_item(OP_SAMPLE, 8'($urandom), 7'($urandom), 7'($urandom));
        case ($urandom_range(4, 0))
            0: send_item(OP_EVENT, {CMD_NOTE_OFF, chan}, key, 7'($urandom));
            1: send_item(OP_EVENT, {CMD_NOTE_ON, chan}, key, 7'd0);
            2: begin
                // release of a key that is not sounding
                send_item(OP_EVENT, {CMD_NOTE_OFF, chan}, key + 7'd1, 7'($urandom));
                repeat (2) send_item(OP_SAMPLE, 8'($urandom), 7'($urandom), 7'($urandom));
            end
            3: send_item(OP_STOP, 8'($urandom), 7'($urandom), 7'($urandom));
            default: ;
        endcase
        send_item(OP_SAMPLE, 8'($urandom), 7'($urandom), 7'($urandom));
    endtask

    initial begin : stimulus
        int unsigned ph;
        int unsigned phase_start;
        int unsigned total;
        logic [7:0]  vol;
        do @(posedge aclk); while (!aresetn);

        // directed: field extremes and the corner cases of the note logic
        send_item(OP_SAMPLE, 8'h00, 7'd0,   7'd0);      // silent at reset
        send_item(OP_EVENT,  8'h90, 7'd1,   7'd127);    // lowest key
        send_item(OP_SAMPLE, 8'hFF, 7'd127, 7'd127);
        send_item(OP_SAMPLE, 8'h00, 7'd0,   7'd0);
        send_item(OP_EVENT,  8'h9F, 7'd127, 7'd1);      // highest key
        repeat (3) send_item(OP_SAMPLE, 8'h00, 7'd0, 7'd0);
        send_item(OP_EVENT,  8'h85, 7'd5,   7'd64);     // release of another key
        send_item(OP_SAMPLE, 8'h00, 7'd0,   7'd0);
        send_item(OP_EVENT,  8'h90, 7'd127, 7'd0);      // zero velocity releases
        send_item(OP_SAMPLE, 8'h00, 7'd0,   7'd0);
        send_item(OP_EVENT,  8'h93, 7'd60,  7'd100);
        send_item(OP_SAMPLE, 8'h00, 7'd0,   7'd0);
        send_item(OP_EVENT,  8'h90, 7'd0,   7'd50);     // note-on of key zero silences
        send_item(OP_SAMPLE, 8'h00, 7'd0,   7'd0);
        send_item(OP_EVENT,  8'hA0, 7'd30,  7'd127);    // other commands do nothing
        send_item(OP_EVENT,  8'hFF, 7'd127, 7'd127);
        send_item(OP_EVENT,  8'h00, 7'd0,   7'd0);
        send_item(OP_SAMPLE, 8'h00, 7'd0,   7'd0);
        send_item(OP_EVENT,  8'h91, 7'd69,  7'd64);
        send_item(OP_IGNORED, 8'hFF, 7'd127, 7'd127);
        send_item(OP_SAMPLE, 8'h00, 7'd0,   7'd0);
        send_item(OP_STOP,   8'hFF, 7'd127, 7'd127);
        send_item(OP_SAMPLE, 8'h00, 7'd0,   7'd0);
        send_item(OP_EVENT,  8'h8F, 7'd69,  7'd127);
        send_item(OP_SAMPLE, 8'h00, 7'd0,   7'd0);

        total = items_sent + RANDOM_ITEMS;
        ph    = 0;
        while (items_sent < total) begin
            wait_for_samples();
            repeat (SETTLE_CYCLES) @(posedge aclk);
            case (ph)
                0:       vol = 8'hFF;
                1:       vol = 8'h00;
                3:       vol = 8'h01;
                4:       vol = 8'h80;
                default: vol = 8'($urandom);
            endcase
            write_volume(vol);
            gap_max = (ph % 3 == 1) ? 0 : $urandom_range(30, 1);
            if (ph == 2) begin
                holds_asked++;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < total) begin
                if ($urandom_range(99, 0) < 80) begin
                    play_note();
                end else begin
                    send_item(2'($urandom), 8'($urandom), 7'($urandom), 7'($urandom));
                end
            end
            ph++;
        end

        wait_for_samples();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        run_done <= 1'b1;
        repeat (3) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
